FILE: hdl/bgd_pkg.sv
// ----------------------------------------------------------------------------
// bgd_pkg: shared types and constants for the button gesture detector
// Event codes, register indexes, field widths and register reset values.
// ----------------------------------------------------------------------------
package bgd_pkg;

   // field widths
   localparam int TIME_W      = 32;
   localparam int THRESH_W    = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int EVENT_W     = 2;

   // result event codes
   typedef enum logic [EVENT_W-1:0] {
      EV_NONE   = 2'd0,
      EV_CLICK  = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_HOLD   = 2'd3
   } event_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CLICK_MIN     = 8'd0,
      CSR_DOUBLE_WINDOW = 8'd1,
      CSR_HOLD          = 8'd2,
      CSR_DOUBLE_ENABLE = 8'd3
   } csr_index_type;

   // register reset values
   localparam logic [THRESH_W-1:0] CLICK_MIN_RESET     = 16'd50;
   localparam logic [THRESH_W-1:0] DOUBLE_WINDOW_RESET = 16'd300;
   localparam logic [THRESH_W-1:0] HOLD_RESET          = 16'd1000;

endpackage : bgd_pkg

FILE: hdl/bgd_if.sv
// ----------------------------------------------------------------------------
// bgd_if: channel interfaces of the button gesture detector
// Sample input, event output and register write channels, valid/ready.
// ----------------------------------------------------------------------------

// button sample channel
interface bgd_req_if
   import bgd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              button_level;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, output button_level, output now_ms, input ready);
   modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface : bgd_req_if

// event result channel
interface bgd_rsp_if
   import bgd_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [EVENT_W-1:0] event_res;

   modport source (output valid, output event_res, input ready);
   modport sink   (input valid, input event_res, output ready);
endinterface : bgd_rsp_if

// register write channel
interface bgd_csr_if
   import bgd_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface : bgd_csr_if

FILE: hdl/button_gesture_detector.sv
// ----------------------------------------------------------------------------
// button_gesture_detector: click, double click and hold detection
// Each pin sample with its millisecond timestamp yields one event code.
// ----------------------------------------------------------------------------
// Usage
//   req_ch : one transfer per pin sample (button_level, 0 pressed, and a
//            free-running now_ms timestamp that wraps modulo 2^32)
//   rsp_ch : one transfer per sample, event_res 0 none, 1 click,
//            2 double click, 3 hold
//   csr_ch : register writes (index, data), always ready; indexes beyond
//            the register list are ignored
// The event of a sample is in the result register on the cycle after its
// transfer. Throughput is one sample per cycle while rsp_ch takes each
// event, set by the single result register; req_ch.ready stays high while
// that register is empty or being drained in the same cycle.
// When the receiver stalls, the result register holds its event and
// req_ch.ready drops until rsp_ch takes it.
// Reset (synchronous, active high) empties the result register, clears the
// press and pending-click flags, sets the level to released and loads the
// register defaults (50, 300, 1000 ms, double click off).
// ----------------------------------------------------------------------------
module button_gesture_detector
   import bgd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   bgd_req_if.sink   req_ch,
   bgd_rsp_if.source rsp_ch,
   bgd_csr_if.sink   csr_ch
);

   // configuration registers
   logic [THRESH_W-1:0] click_min_ff, click_min_in;
   logic [THRESH_W-1:0] window_ff, window_in;
   logic [THRESH_W-1:0] hold_ff, hold_in;
   logic                dbl_en_ff, dbl_en_in;

   // gesture state
   logic                last_level_ff, last_level_in;
   logic                press_active_ff, press_active_in;
   logic [TIME_W-1:0]   press_start_ff, press_start_in;
   logic                click_pending_ff, click_pending_in;
   logic [TIME_W-1:0]   pending_time_ff, pending_time_in;

   // result register
   logic                out_valid_ff, out_valid_in;
   event_type           event_ff, event_in;

   logic                req_xfer;
   logic [TIME_W-1:0]   press_age;
   logic [TIME_W-1:0]   pending_age;
   logic                age_ge_click;
   logic                age_ge_hold;
   logic                pending_in_window;
   event_type           event_calc;

   // handshakes
   assign csr_ch.ready     = 1'b1;
   assign req_ch.ready     = !out_valid_ff || rsp_ch.ready;
   assign req_xfer         = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.event_res = event_ff;

   // register writes
   always_comb begin
      click_min_in = click_min_ff;
      window_in    = window_ff;
      hold_in      = hold_ff;
      dbl_en_in    = dbl_en_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_CLICK_MIN:     click_min_in = csr_ch.data;
            CSR_DOUBLE_WINDOW: window_in    = csr_ch.data;
            CSR_HOLD:          hold_in      = csr_ch.data;
            CSR_DOUBLE_ENABLE: dbl_en_in    = csr_ch.data[0];
            default:           ;
         endcase
      end
   end

   // wrapped time differences against the thresholds
   assign press_age         = req_ch.now_ms - press_start_ff;
   assign pending_age       = req_ch.now_ms - pending_time_ff;
   assign age_ge_click      = press_age >= TIME_W'(click_min_ff);
   assign age_ge_hold       = press_age >= TIME_W'(hold_ff);
   assign pending_in_window = pending_age <= TIME_W'(window_ff);

   // gesture decision for the sample in transfer
   always_comb begin
      last_level_in    = last_level_ff;
      press_active_in  = press_active_ff;
      press_start_in   = press_start_ff;
      click_pending_in = click_pending_ff;
      pending_time_in  = pending_time_ff;
      event_calc       = EV_NONE;
      priority if (req_ch.button_level != last_level_ff) begin
         last_level_in = req_ch.button_level;
         priority if (press_active_ff && req_ch.button_level) begin
            // release ends the press
            if (age_ge_click) begin
               if (dbl_en_ff) begin
                  if (click_pending_ff && pending_in_window) begin
                     event_calc       = EV_DOUBLE;
                     click_pending_in = 1'b0;
                  end else begin
                     pending_time_in  = req_ch.now_ms;
                     click_pending_in = 1'b1;
                  end
               end else begin
                  event_calc = EV_CLICK;
               end
            end
            press_active_in = 1'b0;
         end else if (!req_ch.button_level) begin
            // falling level starts a press
            press_start_in  = req_ch.now_ms;
            press_active_in = 1'b1;
         end else begin
            // release with no press only tracks the level
         end
      end else if (!req_ch.button_level && press_active_ff) begin
         // held long enough: hold ends the press
         if (age_ge_hold) begin
            event_calc      = EV_HOLD;
            press_active_in = 1'b0;
         end
      end else if (dbl_en_ff && req_ch.button_level && click_pending_ff
                   && !pending_in_window) begin
         // stale pending click flushes as a single click
         event_calc       = EV_CLICK;
         click_pending_in = 1'b0;
      end else begin
         // nothing to report
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      event_in     = event_ff;
      if (req_xfer) begin
         out_valid_in = 1'b1;
         event_in     = event_calc;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         click_min_ff     <= CLICK_MIN_RESET;
         window_ff        <= DOUBLE_WINDOW_RESET;
         hold_ff          <= HOLD_RESET;
         dbl_en_ff        <= 1'b0;
         last_level_ff    <= 1'b1;
         press_active_ff  <= 1'b0;
         click_pending_ff <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         click_min_ff <= click_min_in;
         window_ff    <= window_in;
         hold_ff      <= hold_in;
         dbl_en_ff    <= dbl_en_in;
         out_valid_ff <= out_valid_in;
         if (req_xfer) begin
            last_level_ff    <= last_level_in;
            press_active_ff  <= press_active_in;
            click_pending_ff <= click_pending_in;
         end
      end
   end

   // timestamps and event payload
   always_ff @(posedge clock) begin
      event_ff <= event_in;
      if (req_xfer) begin
         press_start_ff  <= press_start_in;
         pending_time_ff <= pending_time_in;
      end
   end

endmodule : button_gesture_detector

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the button gesture detector
// Drives pin samples with timestamps and checks every event code against
// an internal gesture predictor. Runs directed click, hold and double-click
// cases, then random gesture streams under several register settings and
// sender / receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_top
   import bgd_pkg::*;
   ();

   localparam int CYCLE_LIMIT = 200000;
   // index past the last register, the block ignores it
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 8'd4;

   logic clock;
   logic reset;

   bgd_req_if req_if ();
   bgd_rsp_if rsp_if ();
   bgd_csr_if csr_if ();

   button_gesture_detector DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // predictor registers
   logic [THRESH_W-1:0] click_min;
   logic [THRESH_W-1:0] dbl_window;
   logic [THRESH_W-1:0] hold_time;
   logic                dbl_enable;

   // predictor gesture state
   logic              seen_level;
   logic              pressing;
   logic [TIME_W-1:0] press_time;
   logic              click_waiting;
   logic [TIME_W-1:0] click_time;

   event_type   expected_events[$];
   event_type   want_event;
   int          fail_count;
   int          cycle_count;
   int          sent_count;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   logic [TIME_W-1:0] now_cursor;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // next event code for one pin sample, updates the gesture state
   function automatic event_type predict_gesture(input logic level,
                                                 input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] since_press;
      logic [TIME_W-1:0] since_click;
      event_type         ev;
      since_press = now - press_time;
      since_click = now - click_time;
      ev = EV_NONE;
      if (level != seen_level) begin
         seen_level = level;
         if (pressing && level) begin
            // release of an active press
            if (since_press >= TIME_W'(click_min)) begin
               if (dbl_enable) begin
                  if (click_waiting && since_click <= TIME_W'(dbl_window)) begin
                     ev = EV_DOUBLE;
                     click_waiting = 1'b0;
                  end else begin
                     click_time = now;
                     click_waiting = 1'b1;
                  end
               end else begin
                  ev = EV_CLICK;
               end
            end
            pressing = 1'b0;
         end else if (!level) begin
            press_time = now;
            pressing = 1'b1;
         end
      end else if (!level && pressing) begin
         // still held
         if (since_press >= TIME_W'(hold_time)) begin
            ev = EV_HOLD;
            pressing = 1'b0;
         end
      end else if (dbl_enable && level && click_waiting &&
                   since_click > TIME_W'(dbl_window)) begin
         // pending click timed out
         ev = EV_CLICK;
         click_waiting = 1'b0;
      end
      return ev;
   endfunction

   // one sample transfer, with random idle cycles ahead of it
   task automatic send_sample(input logic level, input logic [TIME_W-1:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid        <= 1'b1;
      req_if.button_level <= level;
      req_if.now_ms       <= now;
      do @(posedge clock); while (!req_if.ready);
      expected_events.push_back(predict_gesture(level, now));
      sent_count++;
   endtask

   // stop sending and wait for every outstanding event
   task automatic wait_idle;
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // one register write transfer
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      unique case (idx)
         CSR_CLICK_MIN:     click_min  = val;
         CSR_DOUBLE_WINDOW: dbl_window = val;
         CSR_HOLD:          hold_time  = val;
         CSR_DOUBLE_ENABLE: dbl_enable = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic load_settings(input logic [THRESH_W-1:0] cmin,
                                input logic [THRESH_W-1:0] win,
                                input logic [THRESH_W-1:0] hold,
                                input logic en);
      write_register(CSR_CLICK_MIN, cmin);
      write_register(CSR_DOUBLE_WINDOW, win);
      write_register(CSR_HOLD, hold);
      write_register(CSR_DOUBLE_ENABLE, {{(CSR_DATA_W-1){1'b0}}, en});
   endtask

   // time step near one of the thresholds, zero, small, or random up to 3 * hold_time + 10
   function automatic logic [TIME_W-1:0] pick_gap();
      int unsigned kind;
      kind = $urandom_range(5);
      unique case (kind)
         0: return '0;
         1: return TIME_W'(click_min) + TIME_W'($urandom_range(2)) - TIME_W'(1);
         2: return TIME_W'(dbl_window) + TIME_W'($urandom_range(2)) - TIME_W'(1);
         3: return TIME_W'(hold_time) + TIME_W'($urandom_range(2)) - TIME_W'(1);
         4: return TIME_W'($urandom_range(0, 3 * int'(hold_time) + 10));
         default: return TIME_W'($urandom_range(100));
      endcase
   endfunction

   // press, held samples, release, released samples; sometimes pure noise
   task automatic random_gesture;
      logic [TIME_W-1:0] press_t;
      logic [TIME_W-1:0] release_t;
      int                n;
      if ($urandom_range(9) == 0) begin
         now_cursor = $urandom;
         send_sample(1'($urandom_range(1)), now_cursor);
      end else begin
         press_t = now_cursor + pick_gap();
         send_sample(1'b0, press_t);
         n = $urandom_range(2);
         repeat (n) send_sample(1'b0, press_t + pick_gap());
         release_t = press_t + pick_gap();
         send_sample(1'b1, release_t);
         now_cursor = release_t;
         n = $urandom_range(2);
         repeat (n) begin
            now_cursor = release_t + pick_gap();
            send_sample(1'b1, now_cursor);
         end
      end
   endtask

   // clicks, short press, hold across timestamp wrap, release after hold
   task automatic test_click_and_hold;
      send_sample(1'b0, 32'd0);
      send_sample(1'b1, 32'd50);
      send_sample(1'b0, 32'd100);
      send_sample(1'b1, 32'd149);
      send_sample(1'b0, 32'hFFFF_FFF0);
      send_sample(1'b0, 32'h0000_03D7);
      send_sample(1'b0, 32'h0000_03D8);
      send_sample(1'b1, 32'h0000_0400);
      send_sample(1'b0, 32'hFFFF_FFFF);
      send_sample(1'b1, 32'h0000_0031);
   endtask

   // double click, pending timeout, stale pending, detection toggled off
   task automatic test_double_click;
      write_register(CSR_UNUSED, 16'hFFFF);
      write_register(CSR_DOUBLE_ENABLE, 16'd1);
      send_sample(1'b0, 32'd2000);
      send_sample(1'b1, 32'd2100);
      send_sample(1'b0, 32'd2200);
      send_sample(1'b1, 32'd2300);
      send_sample(1'b0, 32'd3000);
      send_sample(1'b1, 32'd3100);
      send_sample(1'b1, 32'd3400);
      send_sample(1'b1, 32'd3401);
      send_sample(1'b0, 32'd4000);
      send_sample(1'b1, 32'd4100);
      send_sample(1'b0, 32'd4500);
      send_sample(1'b1, 32'd4600);
      send_sample(1'b0, 32'd5000);
      send_sample(1'b1, 32'd5100);
      wait_idle();
      write_register(CSR_DOUBLE_ENABLE, 16'd0);
      send_sample(1'b1, 32'd9000);
      wait_idle();
      write_register(CSR_DOUBLE_ENABLE, 16'd1);
      send_sample(1'b1, 32'd9001);
   endtask

   task automatic test_random_gestures(input int n_items);
      int start;
      start = sent_count;
      now_cursor = $urandom;
      while (sent_count - start < n_items) random_gesture();
   endtask

   // receiver stalls
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // event checker
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_events.size() == 0) begin
            $display("%0t ns: event_res transfer with none expected, actual %0d",
                     $time, rsp_if.event_res);
            fail_count++;
         end else begin
            want_event = expected_events.pop_front();
            if (rsp_if.event_res !== want_event) begin
               $display("%0t ns: event_res mismatch, expected %0d, actual %0d",
                        $time, want_event, rsp_if.event_res);
               fail_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.button_level = 1'b1;
      req_if.now_ms       = '0;
      rsp_if.ready        = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.index        = '0;
      csr_if.data         = '0;
      fail_count          = 0;
      cycle_count         = 0;
      sent_count          = 0;
      now_cursor          = '0;
      click_min           = CLICK_MIN_RESET;
      dbl_window          = DOUBLE_WINDOW_RESET;
      hold_time           = HOLD_RESET;
      dbl_enable          = 1'b0;
      seen_level          = 1'b1;
      pressing            = 1'b0;
      press_time          = '0;
      click_waiting       = 1'b0;
      click_time          = '0;
      send_idle_pct       = 25;
      recv_idle_pct       = 71;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, register defaults first
      test_click_and_hold();
      wait_idle();
      test_double_click();
      wait_idle();

      // random, sender idles less than receiver
      load_settings(THRESH_W'($urandom_range(150)), THRESH_W'($urandom_range(600)),
                    THRESH_W'($urandom_range(2500)), 1'b1);
      test_random_gestures(110);
      wait_idle();

      // random, receiver idles less than sender, extreme settings
      send_idle_pct = 71;
      recv_idle_pct = 25;
      load_settings('0, '0, '0, 1'b1);
      test_random_gestures(70);
      wait_idle();
      load_settings('1, '1, '1, 1'b1);
      test_random_gestures(70);
      wait_idle();

      // random, no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_settings(THRESH_W'($urandom_range(150)), THRESH_W'($urandom_range(600)),
                    THRESH_W'($urandom_range(2500)), 1'b0);
      test_random_gestures(80);
      wait_idle();
      load_settings(THRESH_W'($urandom_range(150)), THRESH_W'($urandom_range(600)),
                    THRESH_W'($urandom_range(2500)), 1'b1);
      test_random_gestures(80);
      wait_idle();

      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule : tb_top
